[hw/rtl/cfba_pkg.sv]
package cfba_pkg;

  // fixed field widths of the request and response words
  localparam int BLK_W    = 12;
  localparam int BLK_SPAN = 1 << BLK_W;

  typedef logic [BLK_W-1:0] block_t;
  typedef logic             opcode_t;
  typedef logic             status_t;

  localparam opcode_t OP_ALLOC = 1'b0;
  localparam opcode_t OP_FREE  = 1'b1;

  localparam status_t STATUS_OK        = 1'b0;
  localparam status_t STATUS_EXHAUSTED = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_SPILL,
    ST_REFILL
  } state_t;

endpackage

[hw/rtl/cfba_if.sv]
interface cfba_in_if;
  import cfba_pkg::*;

  logic    valid;
  logic    ready;
  opcode_t opcode;
  block_t  block_number;

  modport source(output valid, output opcode, output block_number, input ready);
  modport sink(input valid, input opcode, input block_number, output ready);
endinterface

interface cfba_out_if;
  import cfba_pkg::*;

  logic    valid;
  logic    ready;
  block_t  allocated_block;
  status_t status;

  modport source(output valid, output allocated_block, output status, input ready);
  modport sink(input valid, input allocated_block, input status, output ready);
endinterface

[hw/rtl/cfba_stack_mem.sv]
module cfba_stack_mem #(
  parameter int DEPTH = 200,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  cfba_pkg::block_t wdata,
  input  logic [AW-1:0]   raddr,
  output cfba_pkg::block_t rdata
);
  import cfba_pkg::*;

  block_t mem [DEPTH];
  block_t rd_r;
  logic   e0_valid_r;
  logic   rd_zero_r;

  // entry 0 reads as zero until first written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e0_valid_r <= 1'b0;
    end else if (we && (waddr == '0)) begin
      e0_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_r      <= mem[raddr];
    rd_zero_r <= (raddr == '0) && !e0_valid_r;
  end

  assign rdata = rd_zero_r ? '0 : rd_r;

endmodule

[hw/rtl/cfba_chain_mem.sv]
module cfba_chain_mem #(
  parameter int DEPTH = 819200,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  cfba_pkg::block_t wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output cfba_pkg::block_t rdata
);
  import cfba_pkg::*;

  block_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/chained_free_block_allocator_top.sv]
// chained free-block allocator
// requests arrive on in_req (opcode, block_number); one response word per request
// leaves on out_rsp (allocated_block, status), both valid/ready channels
// a free's response is registered at the accepting edge
// an allocate reads the top of the cached stack when accepted, then decides in ST_POP
// a free into a full stack spills the stack into the chain row of the freed block:
//   the block is busy in ST_SPILL after the accepting edge until the sweep ends
// an allocate that empties the stack refills it from the chain row of the popped
//   block: busy in ST_REFILL after the response is produced, until the sweep ends
// each sweep steps through the single read and write port of each memory
// the response sits in an output register; a new request is taken while the
// previous response is being taken, so a stalled receiver holds off only the next
// request and nothing is dropped
// reset leaves one zero entry (end of chain) in the stack, count one; the chain
// store has no reset and needs no clearing pass
module chained_free_block_allocator_top #(
  parameter int LIST_LEN    = 200,
  parameter int BLOCK_COUNT = 4096
) (
  input logic          clk,
  input logic          rst_n,
  cfba_in_if.sink      in_req,
  cfba_out_if.source   out_rsp
);
  import cfba_pkg::*;

  // only block numbers that fit the word can own a chain row
  localparam int ROWS        = (BLOCK_COUNT > BLK_SPAN) ? BLK_SPAN : BLOCK_COUNT;
  localparam int SW          = $clog2(LIST_LEN);
  localparam int CW          = $clog2(LIST_LEN + 1);
  localparam int CHAIN_DEPTH = ROWS * LIST_LEN;
  localparam int CA_W        = $clog2(CHAIN_DEPTH);

  state_t           state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic [CA_W-1:0]  base_r, base_nxt;
  logic             zero_r, zero_nxt;
  block_t           blk_r, blk_nxt;

  logic             out_valid_r;
  block_t           out_blk_r;
  status_t          out_st_r;

  logic             acc;
  logic             load_out;
  block_t           res_blk;
  status_t          res_st;
  logic [CW-1:0]    cnt_m1;
  logic [CW-1:0]    idx_m1;
  logic             blk_ok;
  logic             top_ok;
  block_t           mul_in;
  logic [31:0]      prod;

  // stack memory port
  logic             st_we;
  logic [SW-1:0]    st_waddr;
  block_t           st_wdata;
  logic [SW-1:0]    st_raddr;
  block_t           st_rdata;

  // chain memory port
  logic             ch_we;
  logic [CA_W-1:0]  ch_waddr;
  block_t           ch_wdata;
  logic             ch_re;
  logic [CA_W-1:0]  ch_raddr;
  block_t           ch_rdata;

  cfba_stack_mem #(
    .DEPTH (LIST_LEN),
    .AW    (SW)
  ) u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  cfba_chain_mem #(
    .DEPTH (CHAIN_DEPTH),
    .AW    (CA_W)
  ) u_chain (
    .clk   (clk),
    .we    (ch_we),
    .waddr (ch_waddr),
    .wdata (ch_wdata),
    .re    (ch_re),
    .raddr (ch_raddr),
    .rdata (ch_rdata)
  );

  assign in_req.ready = (state_r == ST_IDLE) && (!out_valid_r || out_rsp.ready);
  assign acc          = in_req.valid && in_req.ready;

  assign cnt_m1 = count_r - CW'(1);
  assign idx_m1 = idx_r - CW'(1);

  // block zero marks the chain end and is never freed
  assign blk_ok = (in_req.block_number != '0) &&
                  (32'(in_req.block_number) < 32'(BLOCK_COUNT));
  assign top_ok = 32'(st_rdata) < 32'(BLOCK_COUNT);

  // one shared multiplier for the row base: freed block on a spill, popped block on a refill
  assign mul_in = (state_r == ST_POP) ? st_rdata : in_req.block_number;
  assign prod   = 32'(mul_in) * 32'(LIST_LEN);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    base_nxt  = base_r;
    zero_nxt  = zero_r;
    blk_nxt   = blk_r;
    load_out  = 1'b0;
    res_blk   = '0;
    res_st    = STATUS_OK;
    st_we     = 1'b0;
    st_waddr  = count_r[SW-1:0];
    st_wdata  = in_req.block_number;
    st_raddr  = cnt_m1[SW-1:0];
    ch_we     = 1'b0;
    ch_waddr  = base_r + CA_W'(idx_m1);
    ch_wdata  = st_rdata;
    ch_re     = 1'b0;
    ch_raddr  = base_r + CA_W'(idx_r);

    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (in_req.opcode == OP_FREE) begin
            load_out = 1'b1;
            if (blk_ok) begin
              if (count_r >= CW'(LIST_LEN)) begin
                // stack full: spill it under the freed block
                base_nxt  = prod[CA_W-1:0];
                blk_nxt   = in_req.block_number;
                idx_nxt   = '0;
                state_nxt = ST_SPILL;
              end else begin
                st_we     = 1'b1;
                count_nxt = count_r + CW'(1);
              end
            end
          end else if ((count_r == '0) || (count_r > CW'(LIST_LEN))) begin
            load_out = 1'b1;
            res_st   = STATUS_EXHAUSTED;
          end else begin
            // top-of-stack read issued this cycle
            state_nxt = ST_POP;
          end
        end
      end

      ST_POP: begin
        load_out = 1'b1;
        if (st_rdata == '0) begin
          res_st    = STATUS_EXHAUSTED;
          state_nxt = ST_IDLE;
        end else begin
          res_blk   = st_rdata;
          count_nxt = cnt_m1;
          if (count_r == CW'(1)) begin
            // popped the chain link: reload the stack from its row
            idx_nxt   = '0;
            base_nxt  = prod[CA_W-1:0];
            zero_nxt  = !top_ok;
            state_nxt = ST_REFILL;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_SPILL: begin
        // read entry idx, write entry idx-1 into the chain row
        idx_nxt  = idx_r + CW'(1);
        st_raddr = idx_r[SW-1:0];
        ch_we    = (idx_r != '0);
        if (idx_r == CW'(LIST_LEN)) begin
          st_we     = 1'b1;
          st_waddr  = '0;
          st_wdata  = blk_r;
          count_nxt = CW'(1);
          idx_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end

      ST_REFILL: begin
        idx_nxt  = idx_r + CW'(1);
        ch_re    = !zero_r && (idx_r < CW'(LIST_LEN));
        st_we    = (idx_r != '0);
        st_waddr = idx_m1[SW-1:0];
        st_wdata = zero_r ? '0 : ch_rdata;
        if (idx_r == CW'(LIST_LEN)) begin
          count_nxt = CW'(LIST_LEN);
          idx_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= CW'(1);
      idx_r   <= '0;
      zero_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      zero_r  <= zero_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    blk_r  <= blk_nxt;
  end

  // response word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_blk_r <= res_blk;
      out_st_r  <= res_st;
    end
  end

  assign out_rsp.valid           = out_valid_r;
  assign out_rsp.allocated_block = out_blk_r;
  assign out_rsp.status          = out_st_r;

endmodule

[bench/tb_chained_free_block_allocator_top.sv]
module tb_chained_free_block_allocator_top;
  import cfba_pkg::*;

  localparam int LIST_LEN     = 200;
  localparam int BLOCK_COUNT  = 4096;
  localparam int RANDOM_ITEMS = 2000;
  localparam int PHASE_LEN    = RANDOM_ITEMS / 4;
  localparam int N_DIRECTED   = 22;

  // one response word as the allocator should give it
  typedef struct packed {
    block_t  allocated_block;
    status_t status;
  } grant_t;

  // one row of the directed table; typed rows carry their own answer
  typedef struct packed {
    opcode_t op;
    block_t  blk;
    logic    typed;
    block_t  exp_blk;
    status_t exp_st;
  } dir_row_t;

  logic clk;
  logic rst_n;

  cfba_in_if  in_req();
  cfba_out_if out_rsp();

  chained_free_block_allocator_top #(
    .LIST_LEN   (LIST_LEN),
    .BLOCK_COUNT(BLOCK_COUNT)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .out_rsp(out_rsp)
  );

  // own copy of the free list: cached stack, its count and the chain rows
  block_t      free_cache [LIST_LEN];
  int unsigned cache_count;
  block_t      chain_rows [BLOCK_COUNT][LIST_LEN];

  // response words still owed by the allocator, oldest first
  grant_t owed_grants[$];

  int mismatch_count = 0;
  int tx_idle_pct    = 0;
  int rx_stall_pct   = 0;

  // directed table: the extremes, the ignored frees and the exhausted pops
  dir_row_t directed_rows [N_DIRECTED] = '{
    // after reset the only entry is the chain end, so nothing to hand out
    '{OP_ALLOC, 12'h000, 1'b1, 12'h000, STATUS_EXHAUSTED},
    // block zero marks the chain end and is never freed
    '{OP_FREE,  12'h000, 1'b1, 12'h000, STATUS_OK},
    '{OP_ALLOC, 12'h000, 1'b1, 12'h000, STATUS_EXHAUSTED},
    // top block number, then handed straight back; block field ignored on allocate
    '{OP_FREE,  12'hFFF, 1'b1, 12'h000, STATUS_OK},
    '{OP_ALLOC, 12'h123, 1'b1, 12'hFFF, STATUS_OK},
    '{OP_ALLOC, 12'hFFF, 1'b1, 12'h000, STATUS_EXHAUSTED},
    '{OP_FREE,  12'h001, 1'b1, 12'h000, STATUS_OK},
    '{OP_FREE,  12'hAAA, 1'b1, 12'h000, STATUS_OK},
    '{OP_FREE,  12'h555, 1'b1, 12'h000, STATUS_OK},
    '{OP_FREE,  12'h800, 1'b1, 12'h000, STATUS_OK},
    '{OP_ALLOC, 12'h000, 1'b0, 12'h000, STATUS_OK},
    '{OP_ALLOC, 12'h7FF, 1'b0, 12'h000, STATUS_OK},
    // the same block freed twice is simply pushed twice
    '{OP_FREE,  12'h555, 1'b1, 12'h000, STATUS_OK},
    '{OP_FREE,  12'h555, 1'b1, 12'h000, STATUS_OK},
    '{OP_ALLOC, 12'h000, 1'b0, 12'h000, STATUS_OK},
    '{OP_ALLOC, 12'h000, 1'b0, 12'h000, STATUS_OK},
    '{OP_ALLOC, 12'h000, 1'b0, 12'h000, STATUS_OK},
    '{OP_ALLOC, 12'h000, 1'b0, 12'h000, STATUS_OK},
    '{OP_ALLOC, 12'h000, 1'b0, 12'h000, STATUS_OK},
    // chain end on top again: exhausted, and the count must not move
    '{OP_ALLOC, 12'hFFF, 1'b1, 12'h000, STATUS_EXHAUSTED},
    '{OP_FREE,  12'h7FF, 1'b1, 12'h000, STATUS_OK},
    '{OP_FREE,  12'h0FE, 1'b1, 12'h000, STATUS_OK}
  };

  // one request applied to our copy of the free list
  function automatic grant_t run_free_list(input opcode_t op, input block_t blk);
    grant_t g;
    block_t top;
    g.allocated_block = '0;
    g.status          = STATUS_OK;
    if (op == OP_FREE) begin
      if (blk != '0 && blk < BLOCK_COUNT) begin
        if (cache_count >= LIST_LEN) begin
          // full stack spills into the chain row of the freed block
          for (int i = 0; i < LIST_LEN; i++) chain_rows[blk][i] = free_cache[i];
          free_cache[0] = blk;
          cache_count   = 1;
        end else begin
          free_cache[cache_count] = blk;
          cache_count++;
        end
      end
    end else if (cache_count == 0 || cache_count > LIST_LEN) begin
      g.status = STATUS_EXHAUSTED;
    end else begin
      top = free_cache[cache_count-1];
      if (top == '0) begin
        g.status = STATUS_EXHAUSTED;
      end else begin
        cache_count--;
        if (cache_count == 0) begin
          // popped the link: refill from its row and hand the link out too
          for (int i = 0; i < LIST_LEN; i++) begin
            free_cache[i] = (top < BLOCK_COUNT) ? chain_rows[top][i] : '0;
          end
          cache_count = LIST_LEN;
        end
        g.allocated_block = top;
      end
    end
    return g;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("%0t mismatch on %s: got %0h, want %0h", $time, what, got, want);
  endtask

  // offer one request word, wait for it to be taken, then log what it owes
  // entered and left just after a rising edge, so each step sees one nba on valid
  task automatic push_request(input opcode_t op, input block_t blk, input logic typed,
                              input grant_t typed_grant, output grant_t model_grant);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_req.valid <= 1'b0;
      @(posedge clk);
    end
    in_req.valid        <= 1'b1;
    in_req.opcode       <= op;
    in_req.block_number <= blk;
    @(posedge clk);
    while (in_req.ready !== 1'b1) @(posedge clk);
    // taken at this edge
    model_grant = run_free_list(op, blk);
    owed_grants.push_back(typed ? typed_grant : model_grant);
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the allocator hangs
  initial begin
    #5_000_000;
    $display("[chained_free_block_allocator_top] ERROR");
    $finish;
  end

  // response side: random stall, check each word taken against the oldest owed
  initial begin
    grant_t want;
    out_rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_rsp.valid === 1'b1 && out_rsp.ready === 1'b1) begin
        if (owed_grants.size() == 0) begin
          report_mismatch("word with nothing owed", 32'(out_rsp.allocated_block), 32'h0);
        end else begin
          want = owed_grants.pop_front();
          if (out_rsp.allocated_block !== want.allocated_block)
            report_mismatch("allocated_block", 32'(out_rsp.allocated_block),
                            32'(want.allocated_block));
          if (out_rsp.status !== want.status)
            report_mismatch("status", 32'(out_rsp.status), 32'(want.status));
        end
      end
      out_rsp.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // request side: reset, directed table, then random traffic in four idling phases
  initial begin
    grant_t got;
    grant_t typed_grant;
    block_t blocks_in_use[$];
    block_t blk;
    opcode_t op;
    int seg_left;
    int seg_idx;
    int free_pct;
    int pick;
    int idx;

    in_req.valid        <= 1'b0;
    in_req.opcode       <= OP_ALLOC;
    in_req.block_number <= '0;
    rst_n               <= 1'b0;

    // state after reset: a single zero link, count one
    free_cache[0] = '0;
    cache_count   = 1;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, no idling on either side
    foreach (directed_rows[i]) begin
      typed_grant.allocated_block = directed_rows[i].exp_blk;
      typed_grant.status          = directed_rows[i].exp_st;
      push_request(directed_rows[i].op, directed_rows[i].blk, directed_rows[i].typed,
                   typed_grant, got);
    end

    // first two stretches are pure: enough frees to force a spill, then enough
    // allocates to pop the link and force a refill; after that biased runs
    seg_left = 300;
    free_pct = 100;
    seg_idx  = 0;

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_LEN == 0) begin
        // hold off until every owed word has come back, then change idling
        if (owed_grants.size() != 0) begin
          in_req.valid <= 1'b0;
          while (owed_grants.size() != 0) @(posedge clk);
        end
        case (n / PHASE_LEN)
          0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
          1: begin tx_idle_pct = 74; rx_stall_pct = 0;  end
          2: begin tx_idle_pct = 0;  rx_stall_pct = 74; end
          default: begin tx_idle_pct = 24; rx_stall_pct = 24; end
        endcase
      end

      if (seg_left == 0) begin
        seg_idx++;
        if (seg_idx == 1) begin
          seg_left = 260;
          free_pct = 0;
        end else begin
          seg_left = $urandom_range(150, 500);
          free_pct = (seg_idx % 2 == 0) ? 90 : 10;
          if ($urandom_range(3) == 0) free_pct = 50;
        end
      end
      seg_left--;

      op = ($urandom_range(99) < free_pct) ? OP_FREE : OP_ALLOC;
      if (op == OP_FREE) begin
        pick = $urandom_range(99);
        if (pick < 4) begin
          blk = '0;  // noise: chain end, ignored
        end else if (pick < 7) begin
          blk = 12'hFFF;
        end else if (pick < 60 && blocks_in_use.size() != 0) begin
          // well formed: give back a block handed out earlier
          idx = $urandom_range(blocks_in_use.size() - 1);
          blk = blocks_in_use[idx];
          blocks_in_use.delete(idx);
        end else begin
          blk = block_t'($urandom_range(1, BLK_SPAN - 1));
        end
      end else begin
        blk = block_t'($urandom);  // ignored, but every bit toggles
      end

      typed_grant = '0;
      push_request(op, blk, 1'b0, typed_grant, got);
      if (op == OP_ALLOC && got.status == STATUS_OK)
        blocks_in_use.push_back(got.allocated_block);
    end

    // drain, then leave room for a stray word after a refill sweep
    in_req.valid <= 1'b0;
    while (owed_grants.size() != 0) @(posedge clk);
    repeat (2 * LIST_LEN + 8) @(posedge clk);

    if (mismatch_count == 0)
      $display("[chained_free_block_allocator_top] OK");
    else
      $display("[chained_free_block_allocator_top] ERROR");
    $finish;
  end

endmodule

[chained_free_block_allocator_top.f]
hw/rtl/cfba_pkg.sv
hw/rtl/cfba_if.sv
hw/rtl/cfba_stack_mem.sv
hw/rtl/cfba_chain_mem.sv
hw/rtl/chained_free_block_allocator_top.sv
bench/tb_chained_free_block_allocator_top.sv
